/* rtl/frac_pkg.sv */
`default_nettype none
package frac_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int PROD_BITS    = 2 * OPERAND_BITS;
  localparam int SUM_BITS     = PROD_BITS + 1;
  localparam int DIV_BITS     = SUM_BITS;
  localparam int SHIFT_BITS   = $clog2(PROD_BITS + 1);
  localparam int CNT_BITS     = $clog2(DIV_BITS);
  localparam int NUM_BITS     = 33;
  localparam int DEN_BITS     = 31;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_WHOLE = 2'd1,
    KIND_FRAC  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_TWOS,
    S_GCD,
    S_DIV,
    S_FIN,
    S_OUT
  } state_e;

  // control shared by every cell of a divider row
  typedef struct packed {
    logic load;
    logic step;
  } row_ctrl_t;

endpackage
`default_nettype wire

/* rtl/frac_cell.sv */
`default_nettype none
module frac_cell
  import frac_pkg::*;
(
  input  wire            clk_i,
  input  wire row_ctrl_t ctrl_i,
  input  wire            load_bit_i,
  input  wire            shift_r_i,
  input  wire            shift_q_i,
  input  wire            div_bit_i,
  input  wire            borrow_i,
  input  wire            commit_i,
  output logic           r_o,
  output logic           q_o,
  output logic           borrow_o
);

  logic r_q, r_d, q_q, q_d, diff;

  // one bit of the trial subtract
  assign diff     = shift_r_i ^ div_bit_i ^ borrow_i;
  assign borrow_o = (~shift_r_i & div_bit_i) | (~(shift_r_i ^ div_bit_i) & borrow_i);

  always_comb begin
    r_d = r_q;
    q_d = q_q;
    if (ctrl_i.load) begin
      r_d = 1'b0;
      q_d = load_bit_i;
    end else if (ctrl_i.step) begin
      r_d = commit_i ? diff : shift_r_i;
      q_d = shift_q_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
  end

  assign r_o = r_q;
  assign q_o = q_q;

endmodule
`default_nettype wire

/* rtl/frac_div_row.sv */
`default_nettype none
module frac_div_row
  import frac_pkg::*;
(
  input  wire                 clk_i,
  input  wire  row_ctrl_t     ctrl_i,
  input  wire  [DIV_BITS-1:0] dividend_i,
  input  wire  [DIV_BITS-1:0] divisor_i,
  output logic [DIV_BITS-1:0] quotient_o
);

  logic [DIV_BITS-1:0] r, q, b, sr, sq, bi;
  logic                commit;

  // restoring division, one quotient bit per step
  assign commit = ~b[DIV_BITS-1];

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign sr[i] = q[DIV_BITS-1];
      assign sq[i] = commit;
      assign bi[i] = 1'b0;
    end else begin : g_rest
      assign sr[i] = r[i-1];
      assign sq[i] = q[i-1];
      assign bi[i] = b[i-1];
    end
    frac_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .load_bit_i (dividend_i[i]),
      .shift_r_i  (sr[i]),
      .shift_q_i  (sq[i]),
      .div_bit_i  (divisor_i[i]),
      .borrow_i   (bi[i]),
      .commit_i   (commit),
      .r_o        (r[i]),
      .q_o        (q[i]),
      .borrow_o   (b[i])
    );
  end

  assign quotient_o = q;

endmodule
`default_nettype wire

/* rtl/fraction_add_sub_reduce_top.sv */
`default_nettype none
// Adds or subtracts two signed fractions and returns the sum in lowest terms,
// sign on the numerator. One request at a time: in_stall_o stays high from
// acceptance until the result is taken. After the products and their sum, the
// sequencer runs the binary gcd steps on the cross-multiplied magnitudes; then
// two bit-serial divider rows of 33 cells divide numerator and denominator by
// the gcd in parallel.
module fraction_add_sub_reduce_top
  import frac_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire                        operation_i,
  input  wire signed [OPERAND_BITS-1:0] left_numerator_i,
  input  wire signed [OPERAND_BITS-1:0] left_denominator_i,
  input  wire signed [OPERAND_BITS-1:0] right_numerator_i,
  input  wire signed [OPERAND_BITS-1:0] right_denominator_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic signed [NUM_BITS-1:0] result_numerator_o,
  output logic [DEN_BITS-1:0]        result_denominator_o,
  output logic [1:0]                 result_kind_o
);

  state_e state_q, state_d;

  logic                         sub_q;
  logic signed [OPERAND_BITS-1:0] ln_q, ld_q, rn_q, rd_q;
  logic signed [PROD_BITS-1:0]  p1_q, p2_q, p3_q;
  logic                         err_q, neg_q;
  logic [PROD_BITS-1:0]         mn_q, md_q, a_q, b_q, a_d, b_d;
  logic [SHIFT_BITS-1:0]        k_q, k_d;
  logic [CNT_BITS-1:0]          cnt_q, cnt_d;
  logic [PROD_BITS-1:0]         g_q;
  logic signed [NUM_BITS-1:0]   num_q, num_d;
  logic [DEN_BITS-1:0]          den_q, den_d;
  kind_e                        kind_q, kind_d;

  logic signed [SUM_BITS-1:0]   n_sum;
  logic [SUM_BITS-1:0]          n_abs, p3_abs;
  logic [DIV_BITS-1:0]          qn, qd;
  logic [NUM_BITS-1:0]          qn_ext;
  row_ctrl_t                    row_ctrl;

  // cross-multiplied numerator
  always_comb begin
    if (sub_q) begin
      n_sum = SUM_BITS'(p1_q) - SUM_BITS'(p2_q);
    end else begin
      n_sum = SUM_BITS'(p1_q) + SUM_BITS'(p2_q);
    end
    n_abs  = n_sum[SUM_BITS-1] ? SUM_BITS'(-n_sum) : SUM_BITS'(n_sum);
    p3_abs = p3_q[PROD_BITS-1] ? SUM_BITS'(-SUM_BITS'(p3_q)) : SUM_BITS'(p3_q);
  end

  // divider rows for numerator and denominator
  frac_div_row u_num_row (
    .clk_i      (clk_i),
    .ctrl_i     (row_ctrl),
    .dividend_i (DIV_BITS'(mn_q)),
    .divisor_i  (DIV_BITS'(g_q)),
    .quotient_o (qn)
  );

  frac_div_row u_den_row (
    .clk_i      (clk_i),
    .ctrl_i     (row_ctrl),
    .dividend_i (DIV_BITS'(md_q)),
    .divisor_i  (DIV_BITS'(g_q)),
    .quotient_o (qd)
  );

  assign qn_ext = NUM_BITS'(qn);

  // sequencer
  always_comb begin
    state_d  = state_q;
    a_d      = a_q;
    b_d      = b_q;
    k_d      = k_q;
    cnt_d    = cnt_q;
    num_d    = num_q;
    den_d    = den_q;
    kind_d   = kind_q;
    row_ctrl = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_MUL;
      end
      S_MUL: state_d = S_SUM;
      S_SUM: begin
        if (err_q) begin
          num_d   = '0;
          den_d   = DEN_BITS'(1);
          kind_d  = KIND_ERROR;
          state_d = S_OUT;
        end else if (n_sum == '0) begin
          num_d   = '0;
          den_d   = DEN_BITS'(1);
          kind_d  = KIND_ZERO;
          state_d = S_OUT;
        end else begin
          a_d     = n_abs[PROD_BITS-1:0];
          b_d     = p3_abs[PROD_BITS-1:0];
          k_d     = '0;
          state_d = S_TWOS;
        end
      end
      S_TWOS: begin
        // strip common factors of two
        if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + SHIFT_BITS'(1);
        end else begin
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (a_q == '0) begin
          row_ctrl.load = 1'b1;
          cnt_d         = '0;
          state_d       = S_DIV;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q >= b_q) begin
          a_d = (a_q - b_q) >> 1;
        end else begin
          b_d = (b_q - a_q) >> 1;
        end
      end
      S_DIV: begin
        row_ctrl.step = 1'b1;
        cnt_d         = cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(DIV_BITS - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        num_d   = neg_q ? -$signed(qn_ext) : $signed(qn_ext);
        den_d   = DEN_BITS'(qd);
        kind_d  = (qd == DIV_BITS'(1)) ? KIND_WHOLE : KIND_FRAC;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      sub_q <= operation_i;
      ln_q  <= left_numerator_i;
      ld_q  <= left_denominator_i;
      rn_q  <= right_numerator_i;
      rd_q  <= right_denominator_i;
    end
    if (state_q == S_MUL) begin
      p1_q  <= PROD_BITS'(ln_q * rd_q);
      p2_q  <= PROD_BITS'(rn_q * ld_q);
      p3_q  <= PROD_BITS'(ld_q * rd_q);
      err_q <= (ld_q == '0) || (rd_q == '0);
    end
    if (state_q == S_SUM) begin
      neg_q <= n_sum[SUM_BITS-1] ^ p3_q[PROD_BITS-1];
      mn_q  <= n_abs[PROD_BITS-1:0];
      md_q  <= p3_abs[PROD_BITS-1:0];
    end
    if (state_q == S_GCD && a_q == '0) begin
      g_q <= b_q << k_q;
    end
    a_q    <= a_d;
    b_q    <= b_d;
    k_q    <= k_d;
    cnt_q  <= cnt_d;
    num_q  <= num_d;
    den_q  <= den_d;
    kind_q <= kind_d;
  end

  assign in_stall_o           = (state_q != S_IDLE);
  assign out_valid_o          = (state_q == S_OUT);
  assign result_numerator_o   = num_q;
  assign result_denominator_o = den_q;
  assign result_kind_o        = kind_q;

endmodule
`default_nettype wire
